@@ rtl/fcc_pkg.sv @@
// Shared types for the call count modulo block.
`default_nettype none
package fcc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SUM,
    ST_ADV,
    ST_FIN
  } fcc_state_e;

endpackage
`default_nettype wire

@@ rtl/fcc_mulmod.sv @@
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module fcc_mulmod #(
  parameter int MOD_WIDTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [MOD_WIDTH-1:0] mcand_i,
  input  wire logic [MOD_WIDTH-1:0] mplier_i,
  input  wire logic [MOD_WIDTH-1:0] mod_i,
  output logic                      done_o,
  output logic [MOD_WIDTH-1:0]      prod_o
);

  localparam int CW = $clog2(MOD_WIDTH + 1);

  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [MOD_WIDTH-1:0] acc_q, acc_d;
  logic [MOD_WIDTH-1:0] mcand_q, mcand_d;
  logic [MOD_WIDTH-1:0] mplier_q, mplier_d;
  logic [MOD_WIDTH-1:0] mod_q, mod_d;
  logic [MOD_WIDTH:0]   dbl, sum;

  always_comb begin
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    mod_d    = mod_q;
    // acc = 2*acc mod m, then + mcand mod m when the bit is set
    dbl = {acc_q, 1'b0};
    if (dbl >= {1'b0, mod_q}) begin
      dbl = dbl - {1'b0, mod_q};
    end
    sum = dbl + (mplier_q[MOD_WIDTH-1] ? {1'b0, mcand_q} : '0);
    if (sum >= {1'b0, mod_q}) begin
      sum = sum - {1'b0, mod_q};
    end
    if (start_i) begin
      cnt_d    = CW'(MOD_WIDTH);
      acc_d    = '0;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      mod_d    = mod_i;
    end else if (cnt_q != '0) begin
      cnt_d    = cnt_q - CW'(1);
      acc_d    = sum[MOD_WIDTH-1:0];
      mplier_d = {mplier_q[MOD_WIDTH-2:0], 1'b0};
      done_d   = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    mod_q    <= mod_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

@@ rtl/fib_call_count_mod.sv @@
// Top level: T(n) = 2*F(n+1)-1 mod b by fast doubling over the bits of n.
//
// Usage: drive index_n_i and modulus_i and raise start; the item is taken
// at a rising edge where start is high and busy is low. busy stays high
// until the result is out. The result appears on count_mod_o for exactly
// one cycle with valid_o high; the receiver cannot hold it off.
//
// Each bit of n, MSB first, is one doubling round: three bit-serial
// modular multipliers run side by side, one multiplier bit per cycle. A
// round goes through setup, one multiply step per multiplier bit, done,
// sum and advance; after the last round a final state forms the result
// and raises the strobe. A modulus of zero gives 0 on the cycle after
// acceptance and busy never rises.
//
// One item is worked on at a time; nothing is kept between items.
// Reset returns the control to idle with no strobe pending.
`default_nettype none
module fib_call_count_mod
  import fcc_pkg::*;
#(
  parameter int INDEX_WIDTH = 63,
  parameter int MOD_WIDTH   = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [INDEX_WIDTH-1:0] index_n_i,
  input  wire logic [MOD_WIDTH-1:0]   modulus_i,
  output logic                        valid_o,
  output logic [MOD_WIDTH-1:0]        count_mod_o
);

  localparam int CW = $clog2(INDEX_WIDTH + 1);

  fcc_state_e           state_q, state_d;
  logic                 valid_q, valid_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [INDEX_WIDTH-1:0] n_q, n_d;
  logic [MOD_WIDTH-1:0] m_q, m_d;
  logic [MOD_WIDTH-1:0] a_q, a_d;   // F(k)
  logic [MOD_WIDTH-1:0] b_q, b_d;   // F(k+1)
  logic [MOD_WIDTH-1:0] s_q, s_d;
  logic [MOD_WIDTH-1:0] res_q, res_d;
  logic [MOD_WIDTH-1:0] diff;
  logic [MOD_WIDTH-1:0] twice;
  logic                 mul_start;
  logic                 done_x, done_y, done_z;
  logic [MOD_WIDTH-1:0] prod_x, prod_y, prod_z;

  function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] x,
                                                   input logic [MOD_WIDTH-1:0] y,
                                                   input logic [MOD_WIDTH-1:0] m);
    logic [MOD_WIDTH:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[MOD_WIDTH-1:0];
  endfunction

  function automatic logic [MOD_WIDTH-1:0] sub_mod(input logic [MOD_WIDTH-1:0] x,
                                                   input logic [MOD_WIDTH-1:0] y,
                                                   input logic [MOD_WIDTH-1:0] m);
    logic [MOD_WIDTH:0] t;
    if (x >= y) begin
      t = {1'b0, x} - {1'b0, y};
    end else begin
      t = {1'b0, x} + {1'b0, m} - {1'b0, y};
    end
    return t[MOD_WIDTH-1:0];
  endfunction

  // x = F(k)*(2F(k+1)-F(k)), y = F(k)^2, z = F(k+1)^2
  fcc_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mul_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (a_q),
    .mplier_i (diff),
    .mod_i    (m_q),
    .done_o   (done_x),
    .prod_o   (prod_x)
  );

  fcc_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mul_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (a_q),
    .mplier_i (a_q),
    .mod_i    (m_q),
    .done_o   (done_y),
    .prod_o   (prod_y)
  );

  fcc_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mul_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (b_q),
    .mplier_i (b_q),
    .mod_i    (m_q),
    .done_o   (done_z),
    .prod_o   (prod_z)
  );

  always_comb begin
    state_d   = state_q;
    valid_d   = 1'b0;
    cnt_d     = cnt_q;
    n_d       = n_q;
    m_d       = m_q;
    a_d       = a_q;
    b_d       = b_q;
    s_d       = s_q;
    res_d     = res_q;
    mul_start = 1'b0;
    twice     = add_mod(b_q, b_q, m_q);
    diff      = sub_mod(twice, a_q, m_q);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          n_d   = index_n_i;
          m_d   = modulus_i;
          cnt_d = CW'(INDEX_WIDTH);
          a_d   = '0;
          b_d   = (modulus_i == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
          if (modulus_i == '0) begin
            res_d   = '0;
            valid_d = 1'b1;
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (done_x && done_y && done_z) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        s_d     = add_mod(prod_y, prod_z, m_q);
        state_d = ST_ADV;
      end
      ST_ADV: begin
        // bit set: (F(2k+1), F(2k+2)), else (F(2k), F(2k+1))
        if (n_q[INDEX_WIDTH-1]) begin
          a_d = s_q;
          b_d = add_mod(prod_x, s_q, m_q);
        end else begin
          a_d = prod_x;
          b_d = s_q;
        end
        n_d   = {n_q[INDEX_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        state_d = (cnt_q == CW'(1)) ? ST_FIN : ST_PREP;
      end
      ST_FIN: begin
        res_d   = (twice == '0) ? (m_q - MOD_WIDTH'(1)) : (twice - MOD_WIDTH'(1));
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    m_q   <= m_d;
    a_q   <= a_d;
    b_q   <= b_d;
    s_q   <= s_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign count_mod_o = res_q;

endmodule
`default_nettype wire
